// ===== rtl/sabm_pkg.sv =====
`timescale 1ns / 1ps

package sabm_pkg;

   localparam int ADDR_W   = 32;
   localparam int PREFIX_W = 5;
   localparam int OPCODE_W = 2;
   localparam int STATUS_W = 3;
   localparam int CSR_IDX_W = 2;

   typedef logic [ADDR_W-1:0]   addr_type;
   typedef logic [PREFIX_W-1:0] prefix_type;
   typedef logic [OPCODE_W-1:0] opcode_type;
   typedef logic [STATUS_W-1:0] status_type;
   typedef logic [CSR_IDX_W-1:0] csr_idx_type;

   localparam opcode_type OP_ALLOC   = 2'd0;
   localparam opcode_type OP_RESERVE = 2'd1;
   localparam opcode_type OP_RELEASE = 2'd2;

   localparam status_type ST_OK            = 3'd0;
   localparam status_type ST_FULL          = 3'd1;
   localparam status_type ST_NOT_IN_SUBNET = 3'd2;
   localparam status_type ST_OUT_OF_RANGE  = 3'd3;
   localparam status_type ST_ALREADY_USED  = 3'd4;
   localparam status_type ST_NOT_USED      = 3'd5;

   localparam csr_idx_type CSR_SUBNET_BASE   = 2'd0;
   localparam csr_idx_type CSR_PREFIX_LENGTH = 2'd1;

   localparam addr_type   BASE_RESET   = 32'd0;
   localparam prefix_type PREFIX_RESET = 5'd24;
   localparam addr_type   RANGE_FIRST  = 32'd2;

   typedef struct packed {
      addr_type   subnet_base;
      prefix_type prefix_length;
      logic       restart;
   } cfg_type;

endpackage

// ===== rtl/sabm_req_if.sv =====
`timescale 1ns / 1ps

interface sabm_req_if import sabm_pkg::*; ();
   logic       valid;
   logic       ready;
   opcode_type opcode;
   addr_type   address;

   modport source (output valid, output opcode, output address, input ready);
   modport sink (input valid, input opcode, input address, output ready);
endinterface

// ===== rtl/sabm_rsp_if.sv =====
`timescale 1ns / 1ps

interface sabm_rsp_if import sabm_pkg::*; ();
   logic       valid;
   logic       ready;
   status_type status;
   addr_type   granted_address;

   modport source (output valid, output status, output granted_address, input ready);
   modport sink (input valid, input status, input granted_address, output ready);
endinterface

// ===== rtl/subnet_address_bitmap_allocator.sv =====
// An invalid or rejected beat goes from S_CHECK straight to S_DONE; reserve and release
// pass through S_RMW, and allocate scans in S_SCAN up to the map word (32 hosts) holding
// the first free host, or through every word the subnet spans for a full map.
// One request is in flight at a time; the next is taken once the answer loads and S_IDLE returns.
// Reset and any write to either register start a clearing pass over all WORDS words
// (8 at the default) of the map memory, during which no request is taken.
`timescale 1ns / 1ps

module subnet_address_bitmap_allocator import sabm_pkg::*; #(
   parameter int HOST_BITS_MAX = 8
) (
   input  logic        clock,
   input  logic        reset,
   sabm_req_if.sink    req_chan,
   sabm_rsp_if.source  rsp_chan,
   input  logic        csr_wr_en,
   input  csr_idx_type csr_index,
   input  addr_type    csr_wdata
);

   localparam int DEPTH       = 1 << HOST_BITS_MAX;
   localparam int WORD_W      = (HOST_BITS_MAX < 5) ? DEPTH : 32;
   localparam int WORD_BITS_W = (HOST_BITS_MAX < 5) ? HOST_BITS_MAX : 5;
   localparam int WORDS       = DEPTH / WORD_W;
   localparam int WIDX_W      = (HOST_BITS_MAX > 5) ? HOST_BITS_MAX - 5 : 1;

   addr_type   base_ff, base_in;
   prefix_type prefix_ff, prefix_in;
   cfg_type    cfg;

   logic              mem_wr_en;
   logic [WIDX_W-1:0] mem_wr_addr;
   logic [WORD_W-1:0] mem_wr_data;
   logic              mem_rd_en;
   logic [WIDX_W-1:0] mem_rd_addr;
   logic [WORD_W-1:0] mem_rd_data;
   logic              restart;

   always_comb begin
      base_in   = base_ff;
      prefix_in = prefix_ff;
      restart   = 1'b0;
      if (csr_wr_en) begin
         if (csr_index == CSR_SUBNET_BASE) begin
            base_in = csr_wdata;
            restart = 1'b1;
         end else if (csr_index == CSR_PREFIX_LENGTH) begin
            prefix_in = csr_wdata[PREFIX_W-1:0];
            restart   = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff   <= BASE_RESET;
         prefix_ff <= PREFIX_RESET;
      end else begin
         base_ff   <= base_in;
         prefix_ff <= prefix_in;
      end
   end

   assign cfg.subnet_base   = base_ff;
   assign cfg.prefix_length = prefix_ff;
   assign cfg.restart       = restart;

   sabm_engine #(
      .HOST_BITS_MAX (HOST_BITS_MAX),
      .WORD_W        (WORD_W),
      .WORD_BITS_W   (WORD_BITS_W),
      .WORDS         (WORDS),
      .WIDX_W        (WIDX_W)
   ) u_engine (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_chan    (req_chan),
      .rsp_chan    (rsp_chan),
      .mem_wr_en   (mem_wr_en),
      .mem_wr_addr (mem_wr_addr),
      .mem_wr_data (mem_wr_data),
      .mem_rd_en   (mem_rd_en),
      .mem_rd_addr (mem_rd_addr),
      .mem_rd_data (mem_rd_data)
   );

   sabm_map_ram #(
      .WORD_W (WORD_W),
      .WORDS  (WORDS),
      .AW     (WIDX_W)
   ) u_map_ram (
      .clock      (clock),
      .wr_en      (mem_wr_en),
      .wr_addr    (mem_wr_addr),
      .wr_data    (mem_wr_data),
      .rd_en      (mem_rd_en),
      .rd_addr    (mem_rd_addr),
      .rd_data_ff (mem_rd_data)
   );

endmodule

// ===== rtl/sabm_map_ram.sv =====
`timescale 1ns / 1ps

module sabm_map_ram #(
   parameter int WORD_W = 32,
   parameter int WORDS  = 8,
   parameter int AW     = 3
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [WORD_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [WORD_W-1:0] rd_data_ff
);

   logic [WORD_W-1:0] map_mem [WORDS];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         map_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= map_mem[rd_addr];
      end
   end

endmodule

// ===== rtl/sabm_engine.sv =====
`timescale 1ns / 1ps

module sabm_engine import sabm_pkg::*; #(
   parameter int HOST_BITS_MAX = 8,
   parameter int WORD_W        = 32,
   parameter int WORD_BITS_W   = 5,
   parameter int WORDS         = 8,
   parameter int WIDX_W        = 3
) (
   input  logic              clock,
   input  logic              reset,
   input  cfg_type           cfg,
   sabm_req_if.sink          req_chan,
   sabm_rsp_if.source        rsp_chan,
   output logic              mem_wr_en,
   output logic [WIDX_W-1:0] mem_wr_addr,
   output logic [WORD_W-1:0] mem_wr_data,
   output logic              mem_rd_en,
   output logic [WIDX_W-1:0] mem_rd_addr,
   input  logic [WORD_W-1:0] mem_rd_data
);

   localparam int CNT_W = WIDX_W + 1;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_RMW   = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0]        state_ff, state_in;
   opcode_type        op_ff, op_in;
   addr_type          addr_ff, addr_in;
   status_type        res_stat_ff, res_stat_in;
   addr_type          res_grant_ff, res_grant_in;
   logic              rsp_valid_ff, rsp_valid_in;
   status_type        rsp_stat_ff, rsp_stat_in;
   addr_type          rsp_grant_ff, rsp_grant_in;
   logic              clr_ff, clr_in;
   logic [CNT_W-1:0]  clr_idx_ff, clr_idx_in;
   logic [CNT_W-1:0]  idx_ff, idx_in;
   logic              chk_vld_ff, chk_vld_in;
   logic [WIDX_W-1:0] chk_idx_ff, chk_idx_in;

   logic [5:0]             hb_raw;
   logic [5:0]             hb_c;
   addr_type               low_mask;
   logic [WIDX_W-1:0]      last_word;
   logic [WORD_BITS_W-1:0] last_pos;
   addr_type               host;
   logic                   in_net;
   logic                   in_range;
   logic [WORD_W-1:0]      free_vec;
   logic [WORD_BITS_W-1:0] free_bit;
   logic                   free_any;
   logic [WORD_BITS_W-1:0] op_bit;
   logic [WORD_W-1:0]      op_onehot;
   logic [WORD_W-1:0]      clr_word;
   logic                   op_wr_en;
   logic [WIDX_W-1:0]      op_wr_addr;
   logic [WORD_W-1:0]      op_wr_data;
   logic                   issue;
   logic                   scan_done;
   logic                   out_free;

   always_comb begin
      hb_raw = 6'd32 - {1'b0, cfg.prefix_length};
      if (hb_raw < 6'd2) begin
         hb_c = 6'd2;
      end else if (hb_raw > 6'(HOST_BITS_MAX)) begin
         hb_c = 6'(HOST_BITS_MAX);
      end else begin
         hb_c = hb_raw;
      end
      low_mask  = (32'd1 << hb_c) - 32'd1;
      last_word = WIDX_W'(low_mask >> WORD_BITS_W);
      last_pos  = low_mask[WORD_BITS_W-1:0];
   end

   assign host      = addr_ff & low_mask;
   assign in_net    = (addr_ff & ~low_mask) == (cfg.subnet_base & ~low_mask);
   assign in_range  = (host >= RANGE_FIRST) && (host <= low_mask - 32'd1);
   assign op_bit    = host[WORD_BITS_W-1:0];
   assign op_onehot = WORD_W'(1) << op_bit;

   always_comb begin
      free_bit = '0;
      for (int j = WORD_W - 1; j >= 0; j--) begin
         free_vec[j] = ~mem_rd_data[j] && (WORD_BITS_W'(j) <= last_pos);
         if (free_vec[j]) begin
            free_bit = WORD_BITS_W'(j);
         end
      end
      free_any = |free_vec;
   end

   always_comb begin
      clr_word = '0;
      if (clr_idx_ff[WIDX_W-1:0] == '0) begin
         clr_word[0] = 1'b1;
         clr_word[1] = 1'b1;
      end
      if (clr_idx_ff[WIDX_W-1:0] == last_word) begin
         clr_word[last_pos] = 1'b1;
      end
   end

   assign issue     = (state_ff == S_SCAN) && (idx_ff <= CNT_W'(last_word));
   assign scan_done = chk_vld_ff && (free_any || chk_idx_ff == last_word);
   assign out_free  = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      addr_in      = addr_ff;
      res_stat_in  = res_stat_ff;
      res_grant_in = res_grant_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_stat_in  = rsp_stat_ff;
      rsp_grant_in = rsp_grant_ff;
      clr_in       = clr_ff;
      clr_idx_in   = clr_idx_ff;
      idx_in       = idx_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = chk_idx_ff;
      mem_rd_en    = 1'b0;
      mem_rd_addr  = '0;
      op_wr_en     = 1'b0;
      op_wr_addr   = '0;
      op_wr_data   = '0;

      if (cfg.restart) begin
         clr_in     = 1'b1;
         clr_idx_in = '0;
      end else if (clr_ff) begin
         clr_idx_in = clr_idx_ff + CNT_W'(1);
         if (clr_idx_ff == CNT_W'(WORDS - 1)) begin
            clr_in = 1'b0;
         end
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_chan.valid && req_chan.ready) begin
               op_in    = req_chan.opcode;
               addr_in  = req_chan.address;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            res_grant_in = '0;
            res_stat_in  = ST_OK;
            if (op_ff == OP_ALLOC) begin
               idx_in   = '0;
               state_in = S_SCAN;
            end else if (op_ff == OP_RESERVE || op_ff == OP_RELEASE) begin
               if (!in_net) begin
                  res_stat_in = ST_NOT_IN_SUBNET;
                  state_in    = S_DONE;
               end else if (!in_range) begin
                  res_stat_in = ST_OUT_OF_RANGE;
                  state_in    = S_DONE;
               end else begin
                  mem_rd_en   = 1'b1;
                  mem_rd_addr = WIDX_W'(host >> WORD_BITS_W);
                  state_in    = S_RMW;
               end
            end else begin
               res_stat_in = ST_OUT_OF_RANGE;
               state_in    = S_DONE;
            end
         end
         S_SCAN: begin
            if (issue) begin
               mem_rd_en   = 1'b1;
               mem_rd_addr = idx_ff[WIDX_W-1:0];
               idx_in      = idx_ff + CNT_W'(1);
               chk_vld_in  = !scan_done;
               chk_idx_in  = idx_ff[WIDX_W-1:0];
            end
            if (chk_vld_ff) begin
               if (free_any) begin
                  op_wr_en     = 1'b1;
                  op_wr_addr   = chk_idx_ff;
                  op_wr_data   = mem_rd_data | (WORD_W'(1) << free_bit);
                  res_grant_in = cfg.subnet_base |
                                 ((32'(chk_idx_ff) << WORD_BITS_W) | 32'(free_bit));
                  state_in     = S_DONE;
               end else if (chk_idx_ff == last_word) begin
                  res_stat_in = ST_FULL;
                  state_in    = S_DONE;
               end
            end
         end
         S_RMW: begin
            op_wr_addr = WIDX_W'(host >> WORD_BITS_W);
            if (op_ff == OP_RESERVE) begin
               if ((mem_rd_data & op_onehot) != '0) begin
                  res_stat_in = ST_ALREADY_USED;
               end else begin
                  op_wr_en   = 1'b1;
                  op_wr_data = mem_rd_data | op_onehot;
               end
            end else begin
               if ((mem_rd_data & op_onehot) == '0) begin
                  res_stat_in = ST_NOT_USED;
               end else begin
                  op_wr_en   = 1'b1;
                  op_wr_data = mem_rd_data & ~op_onehot;
               end
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_stat_in  = res_stat_ff;
               rsp_grant_in = res_grant_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      if (clr_ff) begin
         mem_wr_en   = 1'b1;
         mem_wr_addr = clr_idx_ff[WIDX_W-1:0];
         mem_wr_data = clr_word;
      end else begin
         mem_wr_en   = op_wr_en;
         mem_wr_addr = op_wr_addr;
         mem_wr_data = op_wr_data;
      end
   end

   assign req_chan.ready           = (state_ff == S_IDLE) && !clr_ff;
   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.status          = rsp_stat_ff;
   assign rsp_chan.granted_address = rsp_grant_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         clr_ff       <= 1'b1;
         clr_idx_ff   <= '0;
         chk_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         clr_ff       <= clr_in;
         clr_idx_ff   <= clr_idx_in;
         chk_vld_ff   <= chk_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      addr_ff      <= addr_in;
      res_stat_ff  <= res_stat_in;
      res_grant_ff <= res_grant_in;
      rsp_stat_ff  <= rsp_stat_in;
      rsp_grant_ff <= rsp_grant_in;
      idx_ff       <= idx_in;
      chk_idx_ff   <= chk_idx_in;
   end

endmodule

// ===== verif/subnet_address_bitmap_allocator_test.sv =====
`timescale 1ns / 1ps

module subnet_address_bitmap_allocator_test;
   import sabm_pkg::*;

   localparam int HOST_BITS_MAX = 8;
   localparam int MAP_DEPTH = 1 << HOST_BITS_MAX;

   localparam opcode_type  OP_UNUSED    = 2'd3;
   localparam csr_idx_type CSR_SPARE_LO = 2'd2;
   localparam csr_idx_type CSR_SPARE_HI = 2'd3;

   typedef enum int {RX_ALWAYS, RX_COIN, RX_SPARSE, RX_MOSTLY} rx_mode_type;

   typedef struct packed {
      status_type status;
      addr_type   granted;
   } answer_type;

   class pool_tracker;
      addr_type   subnet_base;
      prefix_type prefix_length;
      bit         host_taken [MAP_DEPTH];
      answer_type answers_due [$];
      int         failures;

      function new();
         subnet_base = BASE_RESET;
         prefix_length = PREFIX_RESET;
         failures = 0;
         clear_map();
      endfunction

      function int span_bits();
         int hb;
         hb = 32 - int'(prefix_length);
         if (hb < 2) hb = 2;
         if (hb > HOST_BITS_MAX) hb = HOST_BITS_MAX;
         return hb;
      endfunction

      function int unsigned pool_size();
         return 1 << span_bits();
      endfunction

      function void clear_map();
         int unsigned sz;
         sz = pool_size();
         foreach (host_taken[h]) host_taken[h] = 1'b0;
         host_taken[0] = 1'b1;
         host_taken[1] = 1'b1;
         host_taken[sz - 1] = 1'b1;
      endfunction

      function void write_register(csr_idx_type idx, addr_type value);
         case (idx)
            CSR_SUBNET_BASE: begin
               subnet_base = value;
               clear_map();
            end
            CSR_PREFIX_LENGTH: begin
               prefix_length = value[PREFIX_W-1:0];
               clear_map();
            end
            default: ;
         endcase
      endfunction

      function int pending();
         return answers_due.size();
      endfunction

      function void note_request(opcode_type op, addr_type addr);
         answer_type  ans;
         int unsigned sz;
         int unsigned h;
         addr_type    mask;
         addr_type    host;
         bit          found;
         sz = pool_size();
         mask = addr_type'(sz - 1);
         ans.status = ST_OK;
         ans.granted = '0;
         case (op)
            OP_ALLOC: begin
               found = 1'b0;
               for (h = 0; h < sz; h++) begin
                  if (!host_taken[h]) begin
                     found = 1'b1;
                     break;
                  end
               end
               if (!found || h < RANGE_FIRST) begin
                  ans.status = ST_FULL;
               end else begin
                  host_taken[h] = 1'b1;
                  ans.granted = subnet_base | addr_type'(h);
               end
            end
            OP_RESERVE, OP_RELEASE: begin
               host = addr & mask;
               if ((addr & ~mask) != (subnet_base & ~mask)) begin
                  ans.status = ST_NOT_IN_SUBNET;
               end else if (host < RANGE_FIRST || host > addr_type'(sz - 2)) begin
                  ans.status = ST_OUT_OF_RANGE;
               end else if (op == OP_RESERVE) begin
                  if (host_taken[host]) ans.status = ST_ALREADY_USED;
                  else host_taken[host] = 1'b1;
               end else begin
                  if (!host_taken[host]) ans.status = ST_NOT_USED;
                  else host_taken[host] = 1'b0;
               end
            end
            default: ans.status = ST_OUT_OF_RANGE;
         endcase
         answers_due.push_back(ans);
      endfunction

      function void check_answer(status_type status, addr_type granted);
         answer_type ans;
         if (answers_due.size() == 0) begin
            $error("response beat with no request outstanding: status %0d, granted %h",
                   status, granted);
            failures++;
            return;
         end
         ans = answers_due.pop_front();
         if (status !== ans.status) begin
            $error("status mismatch: expected %0d, actual %0d", ans.status, status);
            failures++;
         end
         if (granted !== ans.granted) begin
            $error("granted_address mismatch: expected %h, actual %h", ans.granted, granted);
            failures++;
         end
      endfunction
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_wr_en;
   csr_idx_type csr_index;
   addr_type    csr_wdata;

   sabm_req_if req_chan ();
   sabm_rsp_if rsp_chan ();

   subnet_address_bitmap_allocator #(
      .HOST_BITS_MAX(HOST_BITS_MAX)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_chan(req_chan),
      .rsp_chan(rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   pool_tracker tracker;

   int          burst_left = 4;
   bit          line_idle = 1'b1;
   int          answers_seen = 0;
   int          hold_left = 0;
   bit          hold_done = 1'b0;
   int          rx_tick = 0;
   rx_mode_type rx_mode = RX_ALWAYS;
   prefix_type  phase_prefix [10] = '{5'd30, 5'd24, 5'd28, 5'd31, 5'd26,
                                      5'd0, 5'd29, 5'd25, 5'd20, 5'd27};

   always #5 clock = ~clock;

   initial begin
      #2000000;
      $display("*** FAILED ***");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         tracker.check_answer(rsp_chan.status, rsp_chan.granted_address);
         answers_seen <= answers_seen + 1;
      end
   end

   // The one long hold-off lets the block back up so that it stalls its input.
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && answers_seen >= 300) begin
         rsp_chan.ready <= 1'b0;
         hold_left <= 400;
         hold_done <= 1'b1;
      end else begin
         case (rx_mode)
            RX_ALWAYS: rsp_chan.ready <= 1'b1;
            RX_COIN:   rsp_chan.ready <= 1'($urandom_range(1));
            RX_SPARSE: rsp_chan.ready <= (rx_tick % 4 == 0);
            default:   rsp_chan.ready <= ($urandom_range(9) != 0);
         endcase
      end
      rx_tick <= rx_tick + 1;
      if (rx_tick % 48 == 0) rx_mode <= rx_mode_type'($urandom_range(3));
   end

   task automatic send_beat(opcode_type op, addr_type addr);
      req_chan.valid <= 1'b1;
      req_chan.opcode <= op;
      req_chan.address <= addr;
      line_idle = 1'b0;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      tracker.note_request(op, addr);
      burst_left--;
      if (burst_left == 0) begin
         req_chan.valid <= 1'b0;
         line_idle = 1'b1;
         repeat ($urandom_range(1, 8)) @(posedge clock);
         burst_left = $urandom_range(1, ($urandom_range(3) == 0) ? 40 : 6);
      end
   endtask

   task automatic wait_idle();
      if (!line_idle) req_chan.valid <= 1'b0;
      line_idle = 1'b1;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_register(csr_idx_type idx, addr_type value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      @(posedge clock);
      tracker.write_register(idx, value);
   endtask

   task automatic send_random(int alloc_pct);
      int          roll;
      int unsigned sz;
      addr_type    mask;
      addr_type    host;
      addr_type    addr;
      opcode_type  op;
      sz = tracker.pool_size();
      mask = addr_type'(sz - 1);
      roll = $urandom_range(99);
      if (roll < alloc_pct) begin
         op = OP_ALLOC;
         addr = $urandom();
      end else if (roll < 95) begin
         op = $urandom_range(1) ? OP_RESERVE : OP_RELEASE;
         if ($urandom_range(7) == 0) host = $urandom_range(sz - 1);
         else host = $urandom_range(sz - 2, 2);
         addr = (tracker.subnet_base & ~mask) | host;
         if ($urandom_range(15) == 0)
            addr ^= addr_type'(1) << $urandom_range(31, tracker.span_bits());
      end else begin
         op = opcode_type'($urandom_range(3));
         addr = $urandom();
      end
      send_beat(op, addr);
   endtask

   task automatic run_phase(prefix_type prefix, int items, int alloc_pct);
      addr_type    base;
      int unsigned sz;
      wait_idle();
      write_register(CSR_PREFIX_LENGTH, addr_type'(prefix));
      sz = tracker.pool_size();
      base = $urandom();
      if ($urandom_range(1)) base &= ~addr_type'(sz - 1);
      write_register(CSR_SUBNET_BASE, base);
      for (int i = 0; i < items; i++) begin
         if (i == items / 2) begin
            wait_idle();
            write_register($urandom_range(1) ? CSR_SPARE_LO : CSR_SPARE_HI, $urandom());
         end
         send_random(alloc_pct);
      end
   endtask

   initial begin
      tracker = new();
      csr_wr_en <= 1'b0;
      csr_index <= CSR_SUBNET_BASE;
      csr_wdata <= '0;
      req_chan.valid <= 1'b0;
      req_chan.opcode <= OP_ALLOC;
      req_chan.address <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // Default subnet: allocation order, range edges, membership and the unused opcode.
      send_beat(OP_ALLOC, 32'h0000_0000);
      send_beat(OP_ALLOC, 32'h0000_0000);
      send_beat(OP_RESERVE, 32'h0000_00FE);
      send_beat(OP_RESERVE, 32'h0000_00FE);
      send_beat(OP_RESERVE, 32'h0000_00FF);
      send_beat(OP_RELEASE, 32'h0000_0000);
      send_beat(OP_RELEASE, 32'h0000_0001);
      send_beat(OP_RELEASE, 32'h0000_0003);
      send_beat(OP_RELEASE, 32'h0000_0003);
      send_beat(OP_RESERVE, 32'h0000_0100);
      send_beat(OP_RELEASE, 32'hFFFF_FFFF);
      send_beat(OP_UNUSED, 32'hFFFF_FFFF);
      send_beat(OP_ALLOC, 32'hFFFF_FFFF);

      // Smallest subnet with host bits set in the base: a single free host, then a full map.
      wait_idle();
      write_register(CSR_SUBNET_BASE, 32'hFFFF_FFFF);
      write_register(CSR_PREFIX_LENGTH, 32'd30);
      send_beat(OP_ALLOC, 32'h0000_0000);
      send_beat(OP_ALLOC, 32'h0000_0000);
      send_beat(OP_RELEASE, 32'hFFFF_FFFE);
      send_beat(OP_RELEASE, 32'hFFFF_FFFE);
      send_beat(OP_RESERVE, 32'hFFFF_FFFE);
      send_beat(OP_RESERVE, 32'hFFFF_FFFF);
      send_beat(OP_RESERVE, 32'h7FFF_FFFE);
      send_beat(OP_ALLOC, 32'h0000_0000);

      foreach (phase_prefix[p]) run_phase(phase_prefix[p], 60, $urandom_range(20, 70));
      run_phase(5'd24, 300, 95);

      wait_idle();
      repeat (16) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
rtl/sabm_pkg.sv
rtl/sabm_req_if.sv
rtl/sabm_rsp_if.sv
rtl/sabm_map_ram.sv
rtl/sabm_engine.sv
rtl/subnet_address_bitmap_allocator.sv
verif/subnet_address_bitmap_allocator_test.sv
